/* hdl/shs_pkg.sv */
// Shared types, constants and functions for the SHA-256/SHA-224 stream hasher.
package shs_pkg;

    typedef logic [7:0][31:0]  hash_t;
    typedef logic [15:0][31:0] sched_t;

    localparam logic [31:0] PAD_WORD = 32'h8000_0000;

    localparam hash_t IV256 = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam hash_t IV224 = {
        32'hbefa4fa4, 32'h64f98fa7, 32'h68581511, 32'hffc00b31,
        32'hf70e5939, 32'h3070dd17, 32'h367cd507, 32'hc1059ed8
    };

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* hdl/sha256_sha224_stream_hasher_top.sv */
// Top level of the SHA-256/SHA-224 stream hasher: sequencer, buffers and digest output.
//
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, data_word, byte_count, last_word | request in
//  out     | out_valid, out_stall, digest_word, word_index, digest_last | request out
//  cfg     | cfg_wr_en, cfg_wr_data                    | register write
//
// A word is pushed into the window; each filled 16-word block is then compressed
// (64 rounds on the single round unit plus one chaining add). A last word adds padding
// pushes (one per cycle, paused by compression), up to two blocks, then 7 or 8 digest words.
// in_stall is high whenever the sequencer is busy; out_stall holds the current digest word.
// Reset loads SHA-256 initial values and clears length and position.
module sha256_sha224_stream_hasher_top
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PUSH = 3'd1;
    localparam logic [2:0] ST_RUN  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [2:0] PH_FIRST  = 3'd0;
    localparam logic [2:0] PH_MARK   = 3'd1;
    localparam logic [2:0] PH_FILL   = 3'd2;
    localparam logic [2:0] PH_LEN_LO = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_EMIT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  pos_reg;
    logic [5:0]  round_reg;
    logic [2:0]  idx_reg;
    logic [63:0] len_reg;
    logic        mode_reg;
    hash_t       cv_reg;
    hash_t       wv_reg;
    sched_t      win_reg;
    logic [31:0] data_reg;
    logic [2:0]  cnt_reg;
    logic        last_reg;

    hash_t       wv_new;
    logic [31:0] sched_new;
    logic [31:0] push_word;
    logic [63:0] bit_len;
    logic [2:0]  cnt_sat;
    logic        in_acc, out_acc;

    shs_round u_round (
        .wv        (wv_reg),
        .win       (win_reg),
        .round_idx (round_reg),
        .wv_new    (wv_new),
        .sched_new (sched_new)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_acc      = in_valid && !in_stall;
    assign out_valid   = (state_reg == ST_OUT);
    assign out_acc     = out_valid && !out_stall;
    assign digest_word = cv_reg[idx_reg];
    assign word_index  = idx_reg;
    assign digest_last = (idx_reg == (mode_reg ? 3'd6 : 3'd7));
    assign bit_len     = {len_reg[60:0], 3'b000};
    assign cnt_sat     = (byte_count > 3'd4) ? 3'd4 : byte_count;

    function automatic logic [2:0] dispatch(input logic [2:0] ph);
        case (ph)
            PH_DONE: dispatch = ST_IDLE;
            PH_EMIT: dispatch = ST_OUT;
            default: dispatch = ST_PUSH;
        endcase
    endfunction

    always_comb
    begin
        push_word  = 32'd0;
        phase_next = phase_reg;
        case (phase_reg)
            PH_FIRST:
            begin
                if (!last_reg)
                begin
                    push_word  = data_reg;
                    phase_next = PH_DONE;
                end
                else
                begin
                    case (cnt_reg)
                        3'd0:    push_word = PAD_WORD;
                        3'd1:    push_word = {data_reg[31:24], 24'h80_0000};
                        3'd2:    push_word = {data_reg[31:16], 16'h8000};
                        3'd3:    push_word = {data_reg[31:8], 8'h80};
                        default: push_word = data_reg;
                    endcase
                    phase_next = (cnt_reg == 3'd4) ? PH_MARK : PH_FILL;
                end
            end
            PH_MARK:
            begin
                push_word  = PAD_WORD;
                phase_next = PH_FILL;
            end
            PH_FILL:
            begin
                if (pos_reg == 4'd14)
                begin
                    push_word  = bit_len[63:32];
                    phase_next = PH_LEN_LO;
                end
            end
            PH_LEN_LO:
            begin
                push_word  = bit_len[31:0];
                phase_next = PH_EMIT;
            end
            default:
            begin
                push_word  = 32'd0;
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_acc) state_next = ST_PUSH;
            ST_PUSH: state_next = (pos_reg == 4'd15) ? ST_RUN : dispatch(phase_next);
            ST_RUN:  if (round_reg == 6'd63) state_next = ST_ADD;
            ST_ADD:  state_next = dispatch(phase_reg);
            ST_OUT:  if (out_acc && digest_last) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_FIRST;
            pos_reg   <= 4'd0;
            round_reg <= 6'd0;
            idx_reg   <= 3'd0;
            len_reg   <= 64'd0;
            mode_reg  <= 1'b0;
            cv_reg    <= IV256;
        end
        else if (cfg_wr_en)
        begin
            mode_reg  <= cfg_wr_data;
            cv_reg    <= cfg_wr_data ? IV224 : IV256;
            len_reg   <= 64'd0;
            pos_reg   <= 4'd0;
            round_reg <= 6'd0;
            idx_reg   <= 3'd0;
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        phase_reg <= PH_FIRST;
                        len_reg   <= len_reg + {61'd0, (last_word ? cnt_sat : 3'd4)};
                    end
                end
                ST_PUSH:
                begin
                    pos_reg   <= pos_reg + 4'd1;
                    phase_reg <= phase_next;
                    round_reg <= 6'd0;
                end
                ST_RUN:
                begin
                    round_reg <= round_reg + 6'd1;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        cv_reg[i] <= cv_reg[i] + wv_reg[i];
                    end
                    idx_reg <= 3'd0;
                end
                ST_OUT:
                begin
                    if (out_acc)
                    begin
                        if (digest_last)
                        begin
                            idx_reg <= 3'd0;
                            cv_reg  <= mode_reg ? IV224 : IV256;
                            len_reg <= 64'd0;
                            pos_reg <= 4'd0;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    idx_reg <= 3'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            data_reg <= data_word;
            cnt_reg  <= cnt_sat;
            last_reg <= last_word;
        end
        if (state_reg == ST_PUSH)
        begin
            win_reg <= {push_word, win_reg[15:1]};
            if (pos_reg == 4'd15)
            begin
                wv_reg <= cv_reg;
            end
        end
        else if (state_reg == ST_RUN)
        begin
            win_reg <= {sched_new, win_reg[15:1]};
            wv_reg  <= wv_new;
        end
    end

endmodule

/* hdl/shs_round.sv */
// One SHA-256 compression round plus the rolling message schedule step.
module shs_round
    import shs_pkg::*;
(
    input  hash_t       wv,
    input  sched_t      win,
    input  logic [5:0]  round_idx,
    output hash_t       wv_new,
    output logic [31:0] sched_new
);

    logic [31:0] a, e, big0, big1, choose, major, t1, s0, s1;

    always_comb
    begin
        a      = wv[0];
        e      = wv[4];
        big1   = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
        choose = (e & wv[5]) ^ (~e & wv[6]);
        t1     = wv[7] + big1 + choose + ROUND_K[round_idx] + win[0];
        big0   = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
        major  = (a & wv[1]) ^ (a & wv[2]) ^ (wv[1] & wv[2]);
        wv_new[7] = wv[6];
        wv_new[6] = wv[5];
        wv_new[5] = e;
        wv_new[4] = wv[3] + t1;
        wv_new[3] = wv[2];
        wv_new[2] = wv[1];
        wv_new[1] = a;
        wv_new[0] = t1 + big0 + major;
        // window holds W[t..t+15]; produce W[t+16]
        s0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
        s1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
        sched_new = win[0] + win[9] + s0 + s1;
    end

endmodule
